### rtl/sbsh_pkg.sv
`timescale 1ns / 1ps

package sbsh_pkg;

    typedef logic [31:0] t_word;
    typedef logic [7:0]  t_byte;
    typedef logic [4:0][31:0] t_chain;

    localparam int unsigned ROUNDS     = 80;
    localparam int unsigned CHAIN_LEN  = 5;
    localparam logic [5:0]  LEN_POS    = 6'd56;
    localparam logic [5:0]  LAST_POS   = 6'd63;
    localparam t_byte       PAD_MARK   = 8'h80;
    localparam logic [2:0]  LAST_INDEX = 3'd4;

    localparam t_chain INIT_CHAIN = '{
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam t_word K0 = 32'h5A827999;
    localparam t_word K1 = 32'h6ED9EBA1;
    localparam t_word K2 = 32'h8F1BBCDC;
    localparam t_word K3 = 32'hCA62C1D6;

    // Control from the byte sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic init;
        logic push;
    } t_core_ctl;

endpackage

### rtl/sbsh_core.sv
`timescale 1ns / 1ps

module sbsh_core (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  sbsh_pkg::t_core_ctl i_ctl,
    input  sbsh_pkg::t_word    i_word,
    output logic               o_done,
    output sbsh_pkg::t_chain   o_chain
);
    import sbsh_pkg::*;

    typedef enum logic [1:0] {C_IDLE, C_ROUND, C_ADD} t_cstate;

    t_cstate     r_state;
    logic [6:0]  r_rnd;
    t_word       r_w [16];
    t_word       r_a, r_b, r_c, r_d, r_e;
    t_chain      r_h;

    t_word       w_mix;
    t_word       w_next;
    t_word       w_f;
    t_word       w_k;
    t_word       w_t;

    // The sixteen-word window slides by one each round; the taps give w[t+16].
    assign w_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_next = {w_mix[30:0], w_mix[31]};

    always_comb begin
        if (r_rnd < 7'd20) begin
            w_f = (r_b & r_c) | (~r_b & r_d);
            w_k = K0;
        end else if (r_rnd < 7'd40) begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K1;
        end else if (r_rnd < 7'd60) begin
            w_f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d);
            w_k = K2;
        end else begin
            w_f = r_b ^ r_c ^ r_d;
            w_k = K3;
        end
    end

    assign w_t     = {r_a[26:0], r_a[31:27]} + w_f + r_e + w_k + r_w[0];
    assign o_done  = (r_state == C_ADD);
    assign o_chain = r_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= C_IDLE;
            r_rnd   <= '0;
            r_h     <= INIT_CHAIN;
        end else begin
            unique case (r_state)
                C_IDLE: begin
                    r_rnd <= '0;
                    if (i_ctl.start) begin
                        r_state <= C_ROUND;
                    end
                end
                C_ROUND: begin
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'(ROUNDS - 1)) begin
                        r_state <= C_ADD;
                    end
                end
                C_ADD: begin
                    r_h[0]  <= r_h[0] + r_a;
                    r_h[1]  <= r_h[1] + r_b;
                    r_h[2]  <= r_h[2] + r_c;
                    r_h[3]  <= r_h[3] + r_d;
                    r_h[4]  <= r_h[4] + r_e;
                    r_state <= C_IDLE;
                end
                default: r_state <= C_IDLE;
            endcase
            if (i_ctl.init) begin
                r_h <= INIT_CHAIN;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.push || r_state == C_ROUND) begin
            for (int i = 0; i < 15; i++) begin
                r_w[i] <= r_w[i + 1];
            end
            r_w[15] <= i_ctl.push ? i_word : w_next;
        end
        if (r_state == C_IDLE && i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (r_state == C_ROUND) begin
            r_a <= w_t;
            r_b <= r_a;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_d <= r_c;
            r_e <= r_d;
        end
    end

endmodule

### rtl/sha1_byte_stream_hasher.sv
`timescale 1ns / 1ps

// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_data_byte, i_has_byte, i_is_last
// digest    out        o_valid / i_stall  o_digest_word, o_word_index, o_last_word
//
// A message byte is taken while the hasher is idle. When it fills the 64-byte
// block the compression unit loads its working words, runs one round per cycle
// and then updates the chain, and the input stalls meanwhile. A last word adds one
// padding byte per cycle plus one or two compressions, then five digest words.
// Reset is synchronous and returns the chain to the initial hash values.
module sha1_byte_stream_hasher (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  sbsh_pkg::t_byte i_data_byte,
    input  logic            i_has_byte,
    input  logic            i_is_last,
    output logic            o_valid,
    input  logic            i_stall,
    output sbsh_pkg::t_word o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    import sbsh_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_PAD, S_COMP, S_OUT} t_state;

    t_state       r_state;
    logic [5:0]   r_pos;
    logic [63:0]  r_bits;
    logic [63:0]  r_len;
    logic [23:0]  r_acc;
    logic         r_pad_act;
    logic         r_pad_first;
    logic         r_len_go;
    logic [2:0]   r_idx;
    logic         r_start;

    logic         in_acc;
    logic         out_acc;
    logic         put_en;
    t_byte        put_byte;
    logic         len_byte;
    logic         wrap;
    logic [63:0]  bits_inc;
    t_core_ctl    core_ctl;
    logic         core_done;
    t_chain       chain;

    assign o_stall  = (r_state != S_IDLE);
    assign o_valid  = (r_state == S_OUT);
    assign in_acc   = i_valid && (r_state == S_IDLE);
    assign out_acc  = o_valid && !i_stall;
    assign bits_inc = r_bits + 64'd8;

    // Length bytes start at position 56, but only once the marker byte is out.
    assign len_byte = !r_pad_first && (r_len_go || r_pos == LEN_POS);

    always_comb begin
        put_en   = 1'b0;
        put_byte = i_data_byte;
        case (r_state)
            S_IDLE: put_en = in_acc && i_has_byte;
            S_PAD: begin
                put_en = 1'b1;
                if (r_pad_first) begin
                    put_byte = PAD_MARK;
                end else if (len_byte) begin
                    put_byte = r_len[63:56];
                end else begin
                    put_byte = '0;
                end
            end
            default: put_en = 1'b0;
        endcase
    end

    assign wrap           = put_en && (r_pos == LAST_POS);
    assign core_ctl.push  = put_en && (r_pos[1:0] == 2'b11);
    assign core_ctl.start = r_start;
    assign core_ctl.init  = out_acc && (r_idx == LAST_INDEX);

    sbsh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_word  ({r_acc, put_byte}),
        .o_done  (core_done),
        .o_chain (chain)
    );

    assign o_digest_word = chain[r_idx];
    assign o_word_index  = r_idx;
    assign o_last_word   = (r_idx == LAST_INDEX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_bits      <= '0;
            r_pad_act   <= 1'b0;
            r_pad_first <= 1'b0;
            r_len_go    <= 1'b0;
            r_idx       <= '0;
            r_start     <= 1'b0;
        end else begin
            // A full block always moves the sequencer into S_COMP.
            r_start <= wrap;
            if (put_en) begin
                r_pos <= r_pos + 6'd1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_has_byte) begin
                            r_bits <= bits_inc;
                        end
                        if (i_is_last) begin
                            r_pad_act   <= 1'b1;
                            r_pad_first <= 1'b1;
                            r_len_go    <= 1'b0;
                        end
                        if (wrap) begin
                            r_state <= S_COMP;
                        end else if (i_is_last) begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    r_pad_first <= 1'b0;
                    if (len_byte) begin
                        r_len_go <= 1'b1;
                    end
                    if (wrap) begin
                        r_state <= S_COMP;
                    end
                end
                S_COMP: begin
                    if (core_done) begin
                        r_idx <= '0;
                        if (!r_pad_act) begin
                            r_state <= S_IDLE;
                        end else if (r_len_go) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_PAD;
                        end
                    end
                end
                S_OUT: begin
                    if (out_acc) begin
                        if (r_idx == LAST_INDEX) begin
                            r_state   <= S_IDLE;
                            r_bits    <= '0;
                            r_pad_act <= 1'b0;
                            r_len_go  <= 1'b0;
                        end else begin
                            r_idx <= r_idx + 3'd1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (put_en) begin
            r_acc <= {r_acc[15:0], put_byte};
        end
        if (in_acc && i_is_last) begin
            r_len <= i_has_byte ? bits_inc : r_bits;
        end else if (r_state == S_PAD && len_byte) begin
            r_len <= {r_len[55:0], 8'h00};
        end
    end

endmodule

### tb/sha1_byte_stream_hasher_tb.sv
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_tb;

    import sbsh_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 300;

    typedef struct {
        t_word      value;
        logic [2:0] pos;
        logic       is_final;
    } t_digest_exp;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    t_byte      i_data_byte;
    logic       i_has_byte;
    logic       i_is_last;
    logic       o_valid;
    logic       i_stall;
    t_word      o_digest_word;
    logic [2:0] o_word_index;
    logic       o_last_word;

    // Shadow of the hashing state.
    t_word       sha_chain [CHAIN_LEN];
    t_word       sha_block [16];
    logic [63:0] msg_bits;
    logic [5:0]  fill_pos;

    t_digest_exp pending_digest [$];
    t_digest_exp head_exp;

    int  errors;
    int  words_fed;
    int  msgs_done;
    int  overflow_msgs;
    int  longest_msg;
    int  digest_checked;
    int  idle_count;
    int  stall_request;
    int  stall_left;
    bit  src_calm;
    bit  sink_calm;

    sha1_byte_stream_hasher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_data_byte   (i_data_byte),
        .i_has_byte    (i_has_byte),
        .i_is_last     (i_is_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_last_word   (o_last_word)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic t_word rotl(input t_word v, input int unsigned n);
        return (v << n) | (v >> (32 - n));
    endfunction

    task automatic run_compression();
        t_word w [80];
        t_word a, b, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++) w[i] = sha_block[i];
        for (int i = 16; i < ROUNDS; i++) begin
            w[i] = rotl(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        end
        a = sha_chain[0];
        b = sha_chain[1];
        c = sha_chain[2];
        d = sha_chain[3];
        e = sha_chain[4];
        for (int i = 0; i < ROUNDS; i++) begin
            if (i < 20) begin
                f = (b & c) | (~b & d);
                k = K0;
            end else if (i < 40) begin
                f = b ^ c ^ d;
                k = K1;
            end else if (i < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K2;
            end else begin
                f = b ^ c ^ d;
                k = K3;
            end
            t = rotl(a, 5) + f + e + k + w[i];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = t;
        end
        sha_chain[0] += a;
        sha_chain[1] += b;
        sha_chain[2] += c;
        sha_chain[3] += d;
        sha_chain[4] += e;
    endtask

    // Bytes go in big-endian; the first byte of a word clears the rest of it.
    task automatic absorb_byte(input t_byte b);
        t_word cur;
        cur = (fill_pos[1:0] == 2'd0) ? '0 : sha_block[fill_pos[5:2]];
        cur = cur | (t_word'(b) << (8 * (3 - fill_pos[1:0])));
        sha_block[fill_pos[5:2]] = cur;
        fill_pos = fill_pos + 6'd1;
        if (fill_pos == 6'd0) run_compression();
    endtask

    task automatic start_message();
        for (int i = 0; i < CHAIN_LEN; i++) sha_chain[i] = INIT_CHAIN[i];
        msg_bits = '0;
        fill_pos = '0;
    endtask

    task automatic predict_word(input t_byte b, input logic hb, input logic last);
        logic [63:0] len;
        if (hb) begin
            absorb_byte(b);
            msg_bits = msg_bits + 64'd8;
        end
        if (!last) return;
        len = msg_bits;
        // No room for the length after the marker byte: one more block follows.
        if (fill_pos >= LEN_POS) overflow_msgs++;
        if (int'(len / 8) > longest_msg) longest_msg = int'(len / 8);
        absorb_byte(PAD_MARK);
        while (fill_pos != LEN_POS) absorb_byte(8'h00);
        for (int i = 7; i >= 0; i--) absorb_byte(len[8*i +: 8]);
        for (int i = 0; i < CHAIN_LEN; i++) begin
            pending_digest.push_back('{sha_chain[i], 3'(i), i == LAST_INDEX});
        end
        start_message();
        msgs_done++;
    endtask

    task automatic send_word(input t_byte b, input logic hb, input logic last);
        while (!src_calm && $urandom_range(99) < 38) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_has_byte  <= hb;
        i_is_last   <= last;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        predict_word(b, hb, last);
        if (hb || last) words_fed++;
    endtask

    task automatic send_message(input int len, input bit noisy);
        bit tail_on_byte;
        tail_on_byte = (len > 0) && ($urandom_range(1) == 1);
        for (int i = 0; i < len; i++) begin
            if (noisy && $urandom_range(99) < 8) send_word(t_byte'($urandom), 1'b0, 1'b0);
            send_word(t_byte'($urandom), 1'b1, tail_on_byte && (i == len - 1));
        end
        if (!tail_on_byte) send_word(t_byte'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        while (pending_digest.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_empty_message();
        send_word(8'hA5, 1'b0, 1'b1);
        send_word(8'h00, 1'b0, 1'b1);
    endtask

    task automatic test_ignored_words();
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h00, 1'b0, 1'b0);
        send_word(8'h5A, 1'b0, 1'b0);
        send_word(8'h62, 1'b1, 1'b1);
    endtask

    task automatic test_short_messages();
        send_word(8'h61, 1'b1, 1'b0);
        send_word(8'h62, 1'b1, 1'b0);
        send_word(8'h63, 1'b1, 1'b1);
        send_word(8'h00, 1'b1, 1'b0);
        send_word(8'hFF, 1'b1, 1'b0);
        send_word(8'h3C, 1'b0, 1'b1);
    endtask

    task automatic test_random_messages(input int target);
        int first;
        int len;
        first = words_fed;
        while (words_fed - first < target) begin
            if ($urandom_range(99) < 20) len = $urandom_range(70, 50);
            else len = $urandom_range(12, 0);
            send_message(len, 1'b1);
        end
    endtask

    task automatic test_back_to_back();
        src_calm  = 1'b1;
        sink_calm = 1'b1;
        send_message($urandom_range(63, 56), 1'b0);
        send_message($urandom_range(4, 0), 1'b0);
        send_message($urandom_range(3, 1), 1'b0);
        src_calm  = 1'b0;
        sink_calm = 1'b0;
    endtask

    task automatic test_output_hold();
        stall_request = HOLD_CYCLES;
        for (int m = 0; m < 4; m++) send_message($urandom_range(5, 0), 1'b0);
    endtask

    // Digest side: check every accepted word, then choose the next stall.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_digest.size() == 0) begin
                $display("%0t: unexpected digest word %h index %0d last %0b",
                         $time, o_digest_word, o_word_index, o_last_word);
                errors++;
            end else begin
                head_exp = pending_digest.pop_front();
                digest_checked++;
                if (o_digest_word !== head_exp.value || o_word_index !== head_exp.pos
                        || o_last_word !== head_exp.is_final) begin
                    $display("%0t: digest mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                             $time, head_exp.value, head_exp.pos, head_exp.is_final,
                             o_digest_word, o_word_index, o_last_word);
                    errors++;
                end
            end
        end
        if (stall_request > 0 && stall_left == 0) begin
            stall_left    = stall_request;
            stall_request = 0;
        end
        if (stall_left > 0) begin
            stall_left--;
            i_stall <= 1'b1;
        end else if (sink_calm) begin
            i_stall <= 1'b0;
        end else begin
            i_stall <= ($urandom_range(99) < 38);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            idle_count <= 0;
        end else if (idle_count >= WATCHDOG_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("** sha1_byte_stream_hasher: FAILED **");
            $finish;
        end else begin
            idle_count <= idle_count + 1;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_data_byte   = '0;
        i_has_byte    = 1'b0;
        i_is_last     = 1'b0;
        i_stall       = 1'b0;
        errors        = 0;
        words_fed     = 0;
        msgs_done     = 0;
        overflow_msgs = 0;
        longest_msg   = 0;
        digest_checked = 0;
        idle_count    = 0;
        stall_request = 0;
        stall_left    = 0;
        src_calm      = 1'b0;
        sink_calm     = 1'b0;
        for (int i = 0; i < 16; i++) sha_block[i] = '0;
        start_message();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_message();
        test_ignored_words();
        test_short_messages();
        test_random_messages(100);
        test_back_to_back();
        test_output_hold();

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Hashed %0d messages (%0d needing an extra padding block, longest %0d bytes)",
                 msgs_done, overflow_msgs, longest_msg);
        $display("from %0d input words; %0d digest words checked", words_fed, digest_checked);
        if (errors == 0) begin
            $display("** sha1_byte_stream_hasher: PASSED **");
        end else begin
            $display("** sha1_byte_stream_hasher: FAILED **");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/sbsh_pkg.sv
rtl/sbsh_core.sv
rtl/sha1_byte_stream_hasher.sv
tb/sha1_byte_stream_hasher_tb.sv
